FILE: src/vmpc_pkg.sv
// ----------------------------------------------------------------------------
// VMPC package
// Shared types and constants for the VMPC stream cipher core.
// ----------------------------------------------------------------------------
package vmpc_pkg;

  // Permutation geometry
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_AW    = $clog2(PERM_DEPTH);

  // Key store default size
  localparam int unsigned KEY_BYTES_DEF = 64;

  // Steps in one key-schedule round
  localparam int unsigned SCHEDULE_STEPS = 768;
  localparam int unsigned STEP_CNT_W     = $clog2(SCHEDULE_STEPS);

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIDX_W = 6;
  localparam int unsigned KLEN_W = 7;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SCHED  = 2'd1,
    CMD_CIPHER = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_IDX,
    ST_MIX,
    ST_PM,
    ST_KS1,
    ST_KS2,
    ST_SWAP1,
    ST_SWAP2,
    ST_FINISH
  } state_e;

endpackage

FILE: src/vmpc_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// VMPC stream cipher core
// Key store, key schedule and byte cipher over one permutation RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transaction:
//   load a key byte, run one key-schedule round, or cipher one data byte.
//   Output channel (out_valid_o/out_ready_i) returns one byte per command:
//   the ciphered byte for a cipher command, zero otherwise.
// Sequencing (accept to result in the output register):
//   load or unused command : straight to FINISH, no permutation access
//   cipher command         : START, IDX, MIX, PM, KS1, KS2, SWAP1, SWAP2
//   schedule round         : 768 steps of START, IDX, MIX, PM, SWAP1, SWAP2
//   Every command then passes FINISH, which waits for the output register.
//   All permutation traffic goes through the single read/write port pair of
//   the permutation RAM; each schedule step and each cipher byte is a chain
//   of dependent reads followed by two swap writes.
//   One command is in flight at a time; in_ready_o is high only when idle.
// Reset: permutation reads as identity (per-entry valid bits), mix and step
//   indices are zero, key store contents are undefined until loaded.
// Stall: while out_ready_i is low a finished result waits in the output
//   register; a new command may still be accepted, and its result waits
//   until the register drains.
// ----------------------------------------------------------------------------
module vmpc_stream_cipher_core
  import vmpc_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [KIDX_W-1:0] key_index_i,
  input  logic [KLEN_W-1:0] key_len_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o
);

  localparam int unsigned KEY_AW = $clog2(KEY_BYTES);

  state_e state_q, state_d;

  // Control state
  logic [PERM_DEPTH-1:0] valid_q, valid_d;
  logic [PERM_AW-1:0]    step_q, step_d;
  logic [PERM_AW-1:0]    mix_q, mix_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_AW-1:0]     k_q, k_d;
  logic                  sched_q, sched_d;
  logic                  out_vld_q, out_vld_d;

  // Payload registers
  logic [BYTE_W-1:0]     ps_q, ps_d;
  logic [BYTE_W-1:0]     pm_q, pm_d;
  logic [BYTE_W-1:0]     data_q, data_d;
  logic [BYTE_W-1:0]     res_q, res_d;
  logic [KLEN_W-1:0]     len_q, len_d;
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;
  logic [PERM_AW-1:0]    praddr_q;

  // Memory ports
  logic                  perm_we;
  logic [PERM_AW-1:0]    perm_waddr;
  logic [BYTE_W-1:0]     perm_wdata;
  logic [PERM_AW-1:0]    perm_raddr;
  logic [BYTE_W-1:0]     perm_rdata;
  logic                  key_we;
  logic [KEY_AW-1:0]     key_raddr;
  logic [BYTE_W-1:0]     key_rdata;

  // Shared adder operands
  logic [BYTE_W-1:0]     add_a, add_b, add_c, add_sum;

  logic                  accept;
  logic                  out_free;
  logic [BYTE_W-1:0]     pr;
  logic                  last_step;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;

  // Permutation read: entries not written since reset or a restart read as their own index
  assign pr = valid_q[praddr_q] ? perm_rdata : praddr_q;

  assign add_sum   = add_a + add_b + add_c;
  assign last_step = (cnt_q == STEP_CNT_W'(SCHEDULE_STEPS - 1));

  assign key_we = accept && (cmd_e'(cmd_i) == CMD_LOAD)
                  && ({1'b0, key_index_i} < KLEN_W'(KEY_BYTES));

  vmpc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (perm_we),
    .waddr_i(perm_waddr),
    .wdata_i(perm_wdata),
    .raddr_i(perm_raddr),
    .rdata_o(perm_rdata)
  );

  vmpc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(KEY_BYTES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_index_i[KEY_AW-1:0]),
    .wdata_i(data_byte_i),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_SCHED:  state_d = ST_START;
            CMD_CIPHER: state_d = ST_START;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_START:  state_d = ST_IDX;
      ST_IDX:    state_d = ST_MIX;
      ST_MIX:    state_d = ST_PM;
      ST_PM:     state_d = sched_q ? ST_SWAP1 : ST_KS1;
      ST_KS1:    state_d = ST_KS2;
      ST_KS2:    state_d = ST_SWAP1;
      ST_SWAP1:  state_d = ST_SWAP2;
      ST_SWAP2:  state_d = (sched_q && !last_step) ? ST_START : ST_FINISH;
      ST_FINISH: state_d = out_free ? ST_IDLE : ST_FINISH;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    valid_d    = valid_q;
    step_d     = step_q;
    mix_d      = mix_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    sched_d    = sched_q;
    ps_d       = ps_q;
    pm_d       = pm_q;
    data_d     = data_q;
    res_d      = res_q;
    len_d      = len_q;
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    perm_we    = 1'b0;
    perm_waddr = step_q;
    perm_wdata = pm_q;
    perm_raddr = step_q;
    key_raddr  = k_q;
    add_a      = mix_q;
    add_b      = pr;
    add_c      = '0;
    in_ready_o = (state_q == ST_IDLE);

    // Drain output register
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_d  = data_byte_i;
          res_d   = '0;
          sched_d = (cmd_e'(cmd_i) == CMD_SCHED);
          // Clamp key length into 1..KEY_BYTES
          if (key_len_i == '0) begin
            len_d = KLEN_W'(1);
          end else if (key_len_i > KLEN_W'(KEY_BYTES)) begin
            len_d = KLEN_W'(KEY_BYTES);
          end else begin
            len_d = key_len_i;
          end
          if (cmd_e'(cmd_i) == CMD_SCHED) begin
            step_d = '0;
            cnt_d  = '0;
            k_d    = '0;
            if (restart_i) begin
              valid_d = '0;
              mix_d   = '0;
            end
          end
        end
      end
      ST_START: begin
        perm_raddr = step_q;
        key_raddr  = k_q;
      end
      ST_IDX: begin
        ps_d       = pr;
        add_c      = sched_q ? key_rdata : '0;
        perm_raddr = add_sum;
      end
      ST_MIX: begin
        mix_d      = pr;
        perm_raddr = pr;
      end
      ST_PM: begin
        pm_d       = pr;
        perm_raddr = pr;
      end
      ST_KS1: begin
        add_a      = BYTE_W'(1);
        perm_raddr = add_sum;
      end
      ST_KS2: begin
        res_d = data_q ^ pr;
      end
      ST_SWAP1: begin
        perm_we             = 1'b1;
        perm_waddr          = step_q;
        perm_wdata          = pm_q;
        valid_d[step_q]     = 1'b1;
      end
      ST_SWAP2: begin
        perm_we             = 1'b1;
        perm_waddr          = mix_q;
        perm_wdata          = ps_q;
        valid_d[mix_q]      = 1'b1;
        step_d              = step_q + PERM_AW'(1);
        cnt_d               = cnt_q + STEP_CNT_W'(1);
        if ((KLEN_W'(k_q) + KLEN_W'(1)) >= len_q) begin
          k_d = '0;
        end else begin
          k_d = k_q + KEY_AW'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      step_q    <= '0;
      mix_q     <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
      sched_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      step_q    <= step_d;
      mix_q     <= mix_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      sched_q   <= sched_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ps_q       <= ps_d;
    pm_q       <= pm_d;
    data_q     <= data_d;
    res_q      <= res_d;
    len_q      <= len_d;
    out_byte_q <= out_byte_d;
    praddr_q   <= perm_raddr;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

endmodule

FILE: src/vmpc_ram.sv
// ----------------------------------------------------------------------------
// VMPC generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module vmpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/vmpc_checker.sv
// ----------------------------------------------------------------------------
// VMPC port checker
// Concurrent checks on the core's ports, bound to the cipher core.
// ----------------------------------------------------------------------------
module vmpc_checker
  import vmpc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [CMD_W-1:0]  cmd_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_byte_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o))
    else $error("result changed while stalled");

  // One command in flight: ready drops after each accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  // A key load into an empty output register returns zero by way of the FINISH state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && (cmd_i == CMD_LOAD)
    |=> ##1 (out_valid_o && (out_byte_o == '0)))
    else $error("key load result missing or nonzero");

endmodule

bind vmpc_stream_cipher_core vmpc_checker u_vmpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_byte_o (out_byte_o)
);

FILE: test/vmpc_stream_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// VMPC stream cipher core testbench
// Sends key loads, key-schedule rounds, cipher bytes and unused commands
// with random gaps on the input and random stalls on the output. Every
// returned byte is checked against a behavioral model of the cipher
// state, updated in command order as each command is queued.
// ----------------------------------------------------------------------------
module vmpc_stream_cipher_core_tb;
  import vmpc_pkg::*;

  localparam int unsigned      KEY_BYTES      = KEY_BYTES_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
  localparam int               N_RANDOM       = 1600;
  localparam int               RX_HOLD_CYCLES = 400;
  localparam int               IDLE_LIMIT     = 30000;
  localparam int               SETTLE_CYCLES  = 24;
  localparam int               MAX_REPORTS    = 10;

  // Pacing of both channels for a stretch of traffic
  typedef enum int {
    PACE_FLOW,
    PACE_TX_IDLE,
    PACE_RX_STALL,
    PACE_BOTH
  } pace_e;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic [KIDX_W-1:0] kidx;
    logic [KLEN_W-1:0] klen;
    logic              restart;
    logic [BYTE_W-1:0] out_byte;
    pace_e             pace;
    bit                drain_first;
    bit                rx_hold;
  } cmd_txn_t;

  // DUT ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i       = '0;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic [KIDX_W-1:0] key_index_i = '0;
  logic [KLEN_W-1:0] key_len_i   = '0;
  logic              restart_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] out_byte_o;

  // Cipher state as the block should hold it
  logic [7:0] perm_m [PERM_DEPTH];
  logic [7:0] mix_m;
  logic [7:0] step_m;
  logic [7:0] key_m [KEY_BYTES];
  bit         key_loaded [KEY_BYTES];

  // Traffic bookkeeping
  cmd_txn_t pending_cmds [$];
  cmd_txn_t awaiting_bytes [$];
  cmd_txn_t offered;
  pace_e    pace_now;
  pace_e    pace_cur;
  bit       drain_next;
  bit       hold_next;
  int       acc_total;
  int       done_total;
  int       n_acc;
  int       n_done;
  int       err_cnt;
  int       hold_reqs;
  int       hold_seen;
  int       hold_left;
  int       idle_cycles;

  vmpc_stream_cipher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .key_index_i (key_index_i),
    .key_len_i   (key_len_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void swap_perm_m(logic [7:0] a, logic [7:0] b);
    logic [7:0] t;
    t         = perm_m[a];
    perm_m[a] = perm_m[b];
    perm_m[b] = t;
  endfunction

  // One key-schedule round over the first len key bytes, used cyclically
  function automatic void run_key_schedule(logic [KLEN_W-1:0] klen, logic restart);
    int unsigned len;
    int unsigned k;
    int          i;
    logic [7:0]  idx;
    if (klen == 0) len = 1;
    else if (klen > KEY_BYTES) len = KEY_BYTES;
    else len = klen;
    if (restart) begin
      for (i = 0; i < PERM_DEPTH; i++) perm_m[i] = i[7:0];
      mix_m = '0;
    end
    step_m = '0;
    k      = 0;
    for (i = 0; i < SCHEDULE_STEPS; i++) begin
      idx   = mix_m + perm_m[step_m] + key_m[k];
      mix_m = perm_m[idx];
      swap_perm_m(step_m, mix_m);
      k      = (k + 1 >= len) ? 0 : k + 1;
      step_m = step_m + 8'd1;
    end
  endfunction

  // Keystream byte XOR data, then swap and advance the step index
  function automatic logic [7:0] cipher_keystream(logic [7:0] data);
    logic [7:0] idx;
    logic [7:0] ks;
    idx   = mix_m + perm_m[step_m];
    mix_m = perm_m[idx];
    idx   = perm_m[perm_m[mix_m]] + 8'd1;
    ks    = perm_m[idx];
    swap_perm_m(step_m, mix_m);
    step_m = step_m + 8'd1;
    return data ^ ks;
  endfunction

  function automatic logic [7:0] predict_out_byte(cmd_txn_t t);
    logic [7:0] res;
    res = '0;
    case (t.cmd)
      CMD_LOAD: begin
        if (t.kidx < KEY_BYTES) begin
          key_m[t.kidx]      = t.data;
          key_loaded[t.kidx] = 1'b1;
        end
      end
      CMD_SCHED: begin
        run_key_schedule(t.klen, t.restart);
      end
      CMD_CIPHER: begin
        res = cipher_keystream(t.data);
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  function automatic void queue_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                        logic [KIDX_W-1:0] kidx, logic [KLEN_W-1:0] klen,
                                        logic restart);
    cmd_txn_t t;
    t.cmd         = cmd;
    t.data        = data;
    t.kidx        = kidx;
    t.klen        = klen;
    t.restart     = restart;
    t.pace        = pace_now;
    t.drain_first = drain_next;
    t.rx_hold     = hold_next;
    drain_next    = 1'b0;
    hold_next     = 1'b0;
    t.out_byte    = predict_out_byte(t);
    pending_cmds.push_back(t);
  endfunction

  // Length of the run of loaded key bytes starting at index 0
  function automatic int unsigned loaded_prefix();
    int unsigned n;
    n = 0;
    while (n < KEY_BYTES && key_loaded[n]) n++;
    return n;
  endfunction

  // Encode an effective key length, using the clamped codes now and then
  function automatic logic [KLEN_W-1:0] klen_code(int unsigned len);
    logic [KLEN_W-1:0] code;
    code = len;
    if (len == 1 && $urandom_range(2) == 0) code = '0;
    if (len == KEY_BYTES && $urandom_range(1) == 0)
      code = $urandom_range((1 << KLEN_W) - 1, KEY_BYTES + 1);
    return code;
  endfunction

  // Input driver: offer queued transactions, hold each until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_txn_t nxt;
    bit       idle;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cmd_i       <= '0;
      data_byte_i <= '0;
      key_index_i <= '0;
      key_len_i   <= '0;
      restart_i   <= 1'b0;
      n_acc       <= 0;
      pace_cur    <= PACE_FLOW;
      hold_reqs   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        awaiting_bytes.push_back(offered);
        acc_total++;
        n_acc <= acc_total;
      end
      if (!in_valid_i || in_ready_o) begin
        idle = 1'b1;
        if (pending_cmds.size() != 0) begin
          nxt = pending_cmds[0];
          if (nxt.drain_first && n_done != acc_total) idle = 1'b1;
          else if (nxt.pace == PACE_TX_IDLE) idle = ($urandom_range(99) < 80);
          else if (nxt.pace == PACE_BOTH) idle = ($urandom_range(99) < 24);
          else idle = 1'b0;
        end
        if (!idle) begin
          offered     = pending_cmds.pop_front();
          cmd_i       <= offered.cmd;
          data_byte_i <= offered.data;
          key_index_i <= offered.kidx;
          key_len_i   <= offered.klen;
          restart_i   <= offered.restart;
          pace_cur    <= offered.pace;
          if (offered.rx_hold) hold_reqs <= hold_reqs + 1;
        end
        in_valid_i <= !idle;
      end
    end
  end

  // Output monitor: check each transaction, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_txn_t got;
    bit       rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      n_done      <= 0;
      hold_seen   <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (done_total >= n_acc) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected result %02h with no command outstanding", out_byte_o);
        end else begin
          got = awaiting_bytes.pop_front();
          if (got.out_byte !== out_byte_o) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("out_byte mismatch on result %0d (cmd %0d): expected %02h, got %02h",
                       done_total, got.cmd, got.out_byte, out_byte_o);
          end
          done_total++;
          n_done <= done_total;
        end
      end
      rdy = 1'b1;
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= RX_HOLD_CYCLES;
        rdy = 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (pace_cur == PACE_RX_STALL) begin
        rdy = ($urandom_range(99) >= 80);
      end else if (pace_cur == PACE_BOTH) begin
        rdy = ($urandom_range(99) >= 24);
      end
      out_ready_i <= rdy;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vmpc_stream_cipher_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int          seq;
    int unsigned nkeys;
    int unsigned nbytes;
    int unsigned len;
    int unsigned r;
    int          i;
    acc_total   = 0;
    done_total  = 0;
    err_cnt     = 0;
    idle_cycles = 0;
    drain_next  = 1'b0;
    hold_next   = 1'b0;
    pace_now    = PACE_FLOW;
    for (i = 0; i < PERM_DEPTH; i++) perm_m[i] = i[7:0];
    for (i = 0; i < KEY_BYTES; i++) begin
      key_m[i]      = '0;
      key_loaded[i] = 1'b0;
    end
    mix_m  = '0;
    step_m = '0;

    // Directed: cipher from reset, unused command, clamped key lengths
    queue_command(CMD_CIPHER, 8'h00, 6'd0, 7'd0, 1'b0);
    queue_command(CMD_UNUSED, 8'hff, 6'd63, 7'd127, 1'b1);
    queue_command(CMD_LOAD, 8'hff, 6'd0, 7'd127, 1'b1);
    queue_command(CMD_LOAD, 8'h00, 6'd63, 7'd0, 1'b0);
    queue_command(CMD_LOAD, 8'ha5, 6'd1, 7'd64, 1'b1);
    queue_command(CMD_SCHED, 8'hff, 6'd63, 7'd0, 1'b1);
    queue_command(CMD_CIPHER, 8'hff, 6'd63, 7'd127, 1'b1);
    queue_command(CMD_CIPHER, 8'h00, 6'd0, 7'd0, 1'b0);
    queue_command(CMD_CIPHER, 8'h5a, 6'd21, 7'd42, 1'b1);
    queue_command(CMD_SCHED, 8'h00, 6'd0, 7'd2, 1'b0);
    queue_command(CMD_CIPHER, 8'h3c, 6'd0, 7'd0, 1'b0);
    queue_command(CMD_CIPHER, 8'hc3, 6'd63, 7'd127, 1'b0);
    queue_command(CMD_UNUSED, 8'h00, 6'd0, 7'd0, 1'b0);
    queue_command(CMD_LOAD, 8'h00, 6'd0, 7'd1, 1'b0);
    queue_command(CMD_SCHED, 8'h12, 6'd5, 7'd1, 1'b1);
    queue_command(CMD_CIPHER, 8'hff, 6'd0, 7'd0, 1'b0);
    queue_command(CMD_CIPHER, 8'h00, 6'd0, 7'd0, 1'b0);

    // Random sessions: load key, schedule, optional vector round, stream bytes
    seq = 0;
    while (pending_cmds.size() < N_RANDOM + 17) begin
      pace_now = pace_e'(seq % 4);
      if (seq % 8 == 5) drain_next = 1'b1;
      if (seq == 0) nkeys = KEY_BYTES;
      else if ($urandom_range(9) == 0) nkeys = $urandom_range(KEY_BYTES, 17);
      else nkeys = $urandom_range(16, 1);
      for (i = 0; i < nkeys; i++)
        queue_command(CMD_LOAD, $urandom_range(255), i, $urandom_range(127),
                      $urandom_range(1));
      if (seq == 0) begin
        queue_command(CMD_SCHED, $urandom_range(255), $urandom_range(63), 7'd127, 1'b1);
      end else begin
        queue_command(CMD_SCHED, $urandom_range(255), $urandom_range(63), klen_code(nkeys),
                      $urandom_range(9) != 0);
      end
      // Vector round on top of the keyed permutation
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(nkeys, 1);
        for (i = 0; i < len; i++)
          queue_command(CMD_LOAD, $urandom_range(255), i, $urandom_range(127),
                        $urandom_range(1));
        queue_command(CMD_SCHED, $urandom_range(255), $urandom_range(63), klen_code(len),
                      1'b0);
      end
      if (seq % 8 == 4) hold_next = 1'b1;
      nbytes = $urandom_range(60, 20);
      for (i = 0; i < nbytes; i++) begin
        r = $urandom_range(199);
        if (r < 6) begin
          queue_command(CMD_UNUSED, $urandom_range(255), $urandom_range(63),
                        $urandom_range(127), $urandom_range(1));
        end else if (r < 14) begin
          queue_command(CMD_LOAD, $urandom_range(255), $urandom_range(63),
                        $urandom_range(127), $urandom_range(1));
        end else if (r == 14) begin
          queue_command(CMD_SCHED, $urandom_range(255), $urandom_range(63),
                        klen_code($urandom_range(loaded_prefix(), 1)), $urandom_range(1));
        end else begin
          queue_command(CMD_CIPHER, $urandom_range(255), $urandom_range(63),
                        $urandom_range(127), $urandom_range(1));
        end
      end
      seq++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent and every result back
    while (pending_cmds.size() != 0 || in_valid_i || n_done != n_acc) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && awaiting_bytes.size() == 0) begin
      $display("vmpc_stream_cipher_core regression: pass");
    end else begin
      $display("vmpc_stream_cipher_core regression: fail");
    end
    $finish;
  end

endmodule
